>>> hw/rtl/acirf_pkg.sv
// ----------------------------------------------------------------------------
// acirf_pkg
// Shared types, constants and message templates for the air-conditioner
// IR frame builder.
// ----------------------------------------------------------------------------
package acirf_pkg;

    localparam int unsigned MSG_LEN               = 39;
    localparam int unsigned TIMER_MINUTES_MAX_DEF = 1023;

    localparam logic [5:0]  IDX_FIRST      = 6'd0;
    localparam logic [5:0]  IDX_SUM1       = 6'd19;
    localparam logic [5:0]  IDX_FRAME2     = 6'd20;
    localparam logic [5:0]  IDX_TEMP       = 6'd26;
    localparam logic [5:0]  IDX_FAN        = 6'd28;
    localparam logic [5:0]  IDX_LAST       = 6'd38;

    localparam logic [25:0] MS_PER_MINUTE  = 26'd60000;
    localparam logic [2:0]  FAN_LEVELS     = 3'd7;

    localparam logic [6:0]  TEMP_LOW_RST   = 7'd36;
    localparam logic [6:0]  TEMP_HIGH_RST  = 7'd64;
    localparam logic [6:0]  HEAT_DEF_RST   = 7'd55;
    localparam logic [6:0]  COOL_DEF_RST   = 7'd48;
    localparam logic [6:0]  TEMP_RST       = 7'd55;

    // opcodes
    localparam logic [2:0]  OP_SET_MODE    = 3'd0;
    localparam logic [2:0]  OP_TEMP_STEP   = 3'd1;
    localparam logic [2:0]  OP_SET_FAN     = 3'd2;
    localparam logic [2:0]  OP_POWER_OFF   = 3'd3;
    localparam logic [2:0]  OP_SET_TIMER   = 3'd4;
    localparam logic [2:0]  OP_CANCEL      = 3'd5;
    localparam logic [2:0]  OP_TICK        = 3'd6;

    localparam logic [9:0]  ARG_HEAT       = 10'd0;
    localparam logic [9:0]  ARG_COOL       = 10'd1;

    // register indexes (paddr[3:2])
    localparam logic [1:0]  REG_TEMP_LOW   = 2'd0;
    localparam logic [1:0]  REG_TEMP_HIGH  = 2'd1;
    localparam logic [1:0]  REG_HEAT_DEF   = 2'd2;
    localparam logic [1:0]  REG_COOL_DEF   = 2'd3;

    localparam logic [0:6][7:0] FAN_CODES = {
        8'hA0, 8'hB0, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70
    };

    localparam logic [0:38][7:0] COOL_TPL = {
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07,
        8'h00, 8'h00, 8'h10, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAB,
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h39, 8'h30, 8'h00, 8'hA0, 8'h00,
        8'h00, 8'h06, 8'h60, 8'h00, 8'h00, 8'hC3, 8'h00, 8'h00, 8'h44
    };

    localparam logic [0:38][7:0] HEAT_TPL = {
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03,
        8'h00, 8'h00, 8'h30, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC7,
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h49, 8'h35, 8'h00, 8'hA0, 8'h00,
        8'h00, 8'h06, 8'h60, 8'h00, 8'h00, 8'hC3, 8'h00, 8'h00, 8'h59
    };

    localparam logic [0:38][7:0] OFF_TPL = {
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
        8'h00, 8'h80, 8'h10, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h26,
        8'h11, 8'hDA, 8'h27, 8'h00, 8'h00, 8'h38, 8'h30, 8'h00, 8'h50, 8'h00,
        8'h00, 8'h06, 8'h60, 8'h00, 8'h00, 8'hC3, 8'h00, 8'h00, 8'hF3
    };

    typedef struct packed {
        logic [2:0] opcode;
        logic [9:0] argument;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       status;
    } out_item_t;

    typedef struct packed {
        logic [6:0] temp_low_limit;
        logic [6:0] temp_high_limit;
        logic [6:0] heat_default_temp;
        logic [6:0] cool_default_temp;
    } cfg_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_RUN,
        EMIT_OFF,
        EMIT_ERR
    } emit_kind_t;

    typedef enum logic [1:0] {
        TPL_HEAT,
        TPL_COOL,
        TPL_OFF
    } tpl_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_item;
        logic       exec;
        logic       load_out;
        emit_kind_t kind;
        logic [5:0] idx;
        logic       last;
    } ctrl_cmd_t;

    typedef struct packed {
        emit_kind_t kind;
        logic       out_free;
    } dp_sts_t;

    function automatic logic [6:0] clamp_temp(
        input logic [7:0] t,
        input logic [6:0] low,
        input logic [6:0] high
    );
        logic [7:0] r;
        r = t;
        if (r < {1'b0, low}) begin
            r = {1'b0, low};
        end
        if (r > {1'b0, high}) begin
            r = {1'b0, high};
        end
        return r[6:0];
    endfunction

    function automatic logic [7:0] tpl_byte(
        input tpl_sel_t   sel,
        input logic [5:0] idx
    );
        logic [7:0] b;
        b = 8'h00;
        if (idx <= IDX_LAST) begin
            case (sel)
                TPL_HEAT: b = HEAT_TPL[idx];
                TPL_COOL: b = COOL_TPL[idx];
                TPL_OFF:  b = OFF_TPL[idx];
                default:  b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage

>>> hw/rtl/acirf_regs.sv
// ----------------------------------------------------------------------------
// acirf_regs
// APB register bank holding the temperature limits and mode defaults.
// ----------------------------------------------------------------------------
module acirf_regs
    import acirf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_low_limit    <= TEMP_LOW_RST;
            cfg_reg.temp_high_limit   <= TEMP_HIGH_RST;
            cfg_reg.heat_default_temp <= HEAT_DEF_RST;
            cfg_reg.cool_default_temp <= COOL_DEF_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_TEMP_LOW:  cfg_reg.temp_low_limit    <= pwdata[6:0];
                REG_TEMP_HIGH: cfg_reg.temp_high_limit   <= pwdata[6:0];
                REG_HEAT_DEF:  cfg_reg.heat_default_temp <= pwdata[6:0];
                REG_COOL_DEF:  cfg_reg.cool_default_temp <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_TEMP_LOW:  prdata = {25'd0, cfg_reg.temp_low_limit};
            REG_TEMP_HIGH: prdata = {25'd0, cfg_reg.temp_high_limit};
            REG_HEAT_DEF:  prdata = {25'd0, cfg_reg.heat_default_temp};
            REG_COOL_DEF:  prdata = {25'd0, cfg_reg.cool_default_temp};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/acirf_ctrl.sv
// ----------------------------------------------------------------------------
// acirf_ctrl
// Sequencer: takes a command, lets the datapath execute it, then walks the
// byte index across the message.
// ----------------------------------------------------------------------------
module acirf_ctrl
    import acirf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    state_t     state_reg, state_next;
    emit_kind_t kind_reg,  kind_next;
    logic [5:0] idx_reg,   idx_next;
    logic       last_byte;

    assign last_byte = (kind_reg == EMIT_ERR) || (idx_reg == IDX_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= EMIT_NONE;
            idx_reg   <= IDX_FIRST;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                kind_next  = sts.kind;
                idx_next   = IDX_FIRST;
                state_next = (sts.kind == EMIT_NONE) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    if (last_byte) begin
                        state_next = ST_IDLE;
                        kind_next  = EMIT_NONE;
                    end else begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.kind      = kind_reg;
        cmd.idx       = idx_reg;
        cmd.last      = last_byte;
        case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_EMIT: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
            end
        endcase
    end

    a_emit_has_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> kind_reg != EMIT_NONE)
        else $error("emitting without a message kind");

    a_idx_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> idx_reg <= IDX_LAST)
        else $error("byte index beyond message end");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && kind_reg == EMIT_ERR) |-> idx_reg == IDX_FIRST)
        else $error("error result spans more than one transfer");

    a_exec_follows_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && s_valid) |=> state_reg == ST_EXEC)
        else $error("accepted command not executed");

endmodule

>>> hw/rtl/acirf_dp.sv
// ----------------------------------------------------------------------------
// acirf_dp
// Unit state, command execution, message byte generation with running
// sum8 checksums, and the output register.
// ----------------------------------------------------------------------------
module acirf_dp
    import acirf_pkg::*;
#(
    parameter int unsigned TIMER_MINUTES_MAX = TIMER_MINUTES_MAX_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  in_item_t  s_data,
    input  cfg_t      cfg,
    input  ctrl_cmd_t cmd,
    output dp_sts_t   sts,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [9:0] MINUTES_MAX = 10'(TIMER_MINUTES_MAX);

    in_item_t   item_reg;
    logic       power_on_reg,    power_on_next;
    logic       cool_mode_reg,   cool_mode_next;
    logic [6:0] temp_reg,        temp_next;
    logic [2:0] fan_reg,         fan_next;
    logic       timer_armed_reg, timer_armed_next;
    logic [25:0] timer_ms_reg,   timer_ms_next;
    logic [7:0] sum_reg,         sum_next;
    logic       out_valid_reg;
    out_item_t  out_data_reg,    out_data_next;

    emit_kind_t kind;
    logic [6:0] mode_temp;
    logic [7:0] step_temp;
    logic [9:0] minutes;
    logic [25:0] timer_ms_set;
    logic [25:0] timer_ms_dec;
    tpl_sel_t   tpl_sel;
    logic [7:0] gen_byte;

    assign sts.kind     = kind;
    assign sts.out_free = !out_valid_reg || m_ready;
    assign m_valid      = out_valid_reg;
    assign m_data       = out_data_reg;

    assign minutes      = (item_reg.argument > MINUTES_MAX) ? MINUTES_MAX : item_reg.argument;
    assign timer_ms_set = 26'(minutes) * MS_PER_MINUTE;
    assign timer_ms_dec = (timer_ms_reg != 26'd0) ? timer_ms_reg - 26'd1 : timer_ms_reg;

    always_comb begin
        mode_temp = temp_reg;
        if (item_reg.argument == ARG_HEAT) begin
            mode_temp = cfg.heat_default_temp;
        end else if (item_reg.argument == ARG_COOL) begin
            mode_temp = cfg.cool_default_temp;
        end
    end

    always_comb begin
        if (item_reg.argument != 10'd0) begin
            step_temp = {1'b0, temp_reg} + 8'd1;
        end else if (temp_reg == 7'd0) begin
            step_temp = 8'd0;
        end else begin
            step_temp = {1'b0, temp_reg} - 8'd1;
        end
    end

    always_comb begin
        kind             = EMIT_NONE;
        power_on_next    = power_on_reg;
        cool_mode_next   = cool_mode_reg;
        temp_next        = temp_reg;
        fan_next         = fan_reg;
        timer_armed_next = timer_armed_reg;
        timer_ms_next    = timer_ms_reg;
        case (item_reg.opcode)
            OP_SET_MODE: begin
                if (item_reg.argument == ARG_HEAT) begin
                    cool_mode_next = 1'b0;
                end else if (item_reg.argument == ARG_COOL) begin
                    cool_mode_next = 1'b1;
                end
                power_on_next = 1'b1;
                temp_next = clamp_temp({1'b0, mode_temp}, cfg.temp_low_limit,
                                       cfg.temp_high_limit);
                kind = EMIT_RUN;
            end
            OP_TEMP_STEP: begin
                temp_next = clamp_temp(step_temp, cfg.temp_low_limit, cfg.temp_high_limit);
                kind = power_on_reg ? EMIT_RUN : EMIT_NONE;
            end
            OP_SET_FAN: begin
                if (item_reg.argument < {7'd0, FAN_LEVELS}) begin
                    fan_next = item_reg.argument[2:0];
                end
                kind = power_on_reg ? EMIT_RUN : EMIT_NONE;
            end
            OP_POWER_OFF: begin
                power_on_next    = 1'b0;
                timer_armed_next = 1'b0;
                timer_ms_next    = 26'd0;
                kind             = EMIT_OFF;
            end
            OP_SET_TIMER: begin
                if (item_reg.argument == 10'd0) begin
                    kind = EMIT_ERR;
                end else begin
                    timer_armed_next = 1'b1;
                    timer_ms_next    = timer_ms_set;
                end
            end
            OP_CANCEL: begin
                timer_armed_next = 1'b0;
                timer_ms_next    = 26'd0;
            end
            OP_TICK: begin
                if (timer_armed_reg) begin
                    if (timer_ms_dec == 26'd0) begin
                        power_on_next    = 1'b0;
                        timer_armed_next = 1'b0;
                        timer_ms_next    = 26'd0;
                        kind             = EMIT_OFF;
                    end else begin
                        timer_ms_next = timer_ms_dec;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (cmd.kind == EMIT_OFF) begin
            tpl_sel = TPL_OFF;
        end else if (cool_mode_reg) begin
            tpl_sel = TPL_COOL;
        end else begin
            tpl_sel = TPL_HEAT;
        end
    end

    always_comb begin
        gen_byte = tpl_byte(tpl_sel, cmd.idx);
        if (cmd.idx == IDX_SUM1 || cmd.idx == IDX_LAST) begin
            gen_byte = sum_reg;
        end else if (cmd.kind == EMIT_RUN && cmd.idx == IDX_TEMP) begin
            gen_byte = {1'b0, clamp_temp({1'b0, temp_reg}, cfg.temp_low_limit,
                                         cfg.temp_high_limit)};
        end else if (cmd.kind == EMIT_RUN && cmd.idx == IDX_FAN) begin
            gen_byte = (fan_reg < FAN_LEVELS) ? FAN_CODES[fan_reg] : FAN_CODES[0];
        end
    end

    always_comb begin
        if (cmd.idx == IDX_FIRST || cmd.idx == IDX_FRAME2) begin
            sum_next = gen_byte;
        end else begin
            sum_next = sum_reg + gen_byte;
        end
    end

    always_comb begin
        if (cmd.kind == EMIT_ERR) begin
            out_data_next.frame_byte = 8'd0;
            out_data_next.byte_index = IDX_FIRST;
            out_data_next.last       = 1'b1;
            out_data_next.status     = 1'b1;
        end else begin
            out_data_next.frame_byte = gen_byte;
            out_data_next.byte_index = cmd.idx;
            out_data_next.last       = cmd.last;
            out_data_next.status     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_on_reg    <= 1'b0;
            cool_mode_reg   <= 1'b0;
            temp_reg        <= TEMP_RST;
            fan_reg         <= 3'd0;
            timer_armed_reg <= 1'b0;
            timer_ms_reg    <= 26'd0;
        end else if (cmd.exec) begin
            power_on_reg    <= power_on_next;
            cool_mode_reg   <= cool_mode_next;
            temp_reg        <= temp_next;
            fan_reg         <= fan_next;
            timer_armed_reg <= timer_armed_next;
            timer_ms_reg    <= timer_ms_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_data;
        end
        if (cmd.load_out) begin
            out_data_reg <= out_data_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !cmd.load_out)
        else $error("output register overwritten while stalled");

    a_armed_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_armed_reg |-> timer_ms_reg != 26'd0)
        else $error("timer armed with no time left");

    a_off_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && kind == EMIT_OFF) |=> (!power_on_reg && !timer_armed_reg))
        else $error("off message left the unit on or armed");

endmodule

>>> hw/rtl/aircon_ir_frame_builder.sv
// ----------------------------------------------------------------------------
// aircon_ir_frame_builder
// Air-conditioner state keeper and 39-byte two-frame IR message builder.
// ----------------------------------------------------------------------------
// Commands enter on the s_ channel (opcode, argument); message bytes leave
// on the m_ channel one transfer per byte, index 0..38, last on byte 38.
// A rejected zero-minute timer gives a single transfer with status set.
// Limits and mode defaults sit in the APB registers; write them only while
// the block is idle.
// A command is taken from the s_ channel and executed in the next cycle.
// A command without output then returns to idle. A message command
// loads its bytes into the output register in index order after execution,
// one byte per cycle while m_ready stays high.
// The byte sequencer handles one command at a time; s_ready returns while
// the final byte still waits in the output register.
// A stalled receiver holds the output register and freezes the sequencer.
// Reset (aresetn low, synchronous) restores the register defaults, powers
// the unit off in heat mode at 27.5 degrees with auto fan and no timer.
// ----------------------------------------------------------------------------
module aircon_ir_frame_builder
    import acirf_pkg::*;
#(
    parameter int unsigned TIMER_MINUTES_MAX = TIMER_MINUTES_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    acirf_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    acirf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    acirf_dp #(
        .TIMER_MINUTES_MAX (TIMER_MINUTES_MAX)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
